// File: hdl/pdh_pkg.sv
package pdh_pkg;

    // default hash length in bytes
    localparam int HASH_BYTES_DEF = 20;

    localparam int CHAR_W = 8;
    localparam int HEX_W  = 7;
    localparam int IDX_W  = 5;

    localparam logic [CHAR_W-1:0] PERCENT_CHAR = 8'h25;
    localparam logic [HEX_W-1:0]  HEX_ZERO     = 7'd48;

    typedef enum logic [1:0] {
        KIND_BYTE   = 2'd0,
        KIND_OK     = 2'd1,
        KIND_SHORT  = 2'd2,
        KIND_BADESC = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_FIRST  = 2'd1,
        PH_SECOND = 2'd2
    } phase_t;

    // lowercase ascii digit for a nibble
    function automatic logic [HEX_W-1:0] hex_digit(input logic [3:0] n);
        if (n < 4'd10)
        begin
            return 7'd48 + {3'b000, n};
        end
        else
        begin
            return 7'd87 + {3'b000, n};
        end
    endfunction

    // {valid, value} of an ascii hex digit, either case
    function automatic logic [4:0] hex_value(input logic [CHAR_W-1:0] ch);
        logic [7:0] d;
        d = 8'd0;
        if (ch >= 8'h30 && ch <= 8'h39)
        begin
            d = ch - 8'h30;
            return {1'b1, d[3:0]};
        end
        else if (ch >= 8'h61 && ch <= 8'h66)
        begin
            d = ch - 8'h57;
            return {1'b1, d[3:0]};
        end
        else if (ch >= 8'h41 && ch <= 8'h46)
        begin
            d = ch - 8'h37;
            return {1'b1, d[3:0]};
        end
        return 5'd0;
    endfunction

endpackage

// File: hdl/percent_decode_hash_to_hex_unit.sv
// percent decoder for a url-encoded hash value
//
// input channel (in_valid / in_stall): one raw character per request, with
// last_char set on the final character of the value. a '%' and two hex
// digits give one byte, any other character is one literal byte.
// output channel (out_valid / out_stall): zero, one or two results per request. kind 0
// carries a decoded byte with its two lowercase hex digits and its index;
// kinds 1..3 close the value (ok, too short, bad escape). a last character
// that also yields a byte gives the byte first, then the status, and
// run_end marks the final result caused by each character.
// a taken character waits in the input register and is then decoded into
// the result buffer, from which its results are shown.
// throughput: one character per cycle, limited only by the result buffer,
// which drains one result per cycle; a closing character with a byte gives
// two results. the input register keeps taking a character while a
// finished result waits, so a stalled receiver costs one character of slack.
// reset clears the escape phase, byte count, error flag and all valid bits;
// after each closing character the decoder returns to that same state.
// while out_stall is high the shown result holds and in_stall rises once
// the input register is full.
module percent_decode_hash_to_hex_unit #(
    parameter int HASH_BYTES = pdh_pkg::HASH_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [pdh_pkg::CHAR_W-1:0]      char_in,
    input  logic                            last_char,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      kind,
    output logic [pdh_pkg::CHAR_W-1:0]      decoded_byte,
    output logic [pdh_pkg::HEX_W-1:0]       hex_high,
    output logic [pdh_pkg::HEX_W-1:0]       hex_low,
    output logic [pdh_pkg::IDX_W-1:0]       byte_index,
    output logic                            run_end
);
    import pdh_pkg::*;

    localparam int CNT_W = $clog2(HASH_BYTES + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(HASH_BYTES);

    // input register
    logic              in_vld_reg;
    logic [CHAR_W-1:0] in_char_reg;
    logic              in_last_reg;

    // decoder state
    phase_t            phase_reg, phase_next;
    logic [3:0]        nib_reg, nib_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              bad_reg, bad_next;

    // result buffer: one byte slot ahead of one status slot
    logic              byte_vld_reg;
    logic              stat_vld_reg;
    logic [CHAR_W-1:0] byte_reg;
    logic [HEX_W-1:0]  hh_reg;
    logic [HEX_W-1:0]  hl_reg;
    logic [IDX_W-1:0]  idx_reg;
    kind_t             stat_kind_reg;

    logic              emit;
    logic [CHAR_W-1:0] emit_byte;
    kind_t             stat_kind;
    logic [4:0]        hv;
    logic              not_full;
    logic              out_take;
    logic              buf_free;
    logic              proc;
    logic [CNT_W-1:0]  cnt_stepped;

    // handshake and flow
    assign out_valid = byte_vld_reg | stat_vld_reg;
    assign out_take  = out_valid & ~out_stall;
    // buffer will be empty after this edge
    assign buf_free  = ~out_valid | (out_take & ~(byte_vld_reg & stat_vld_reg));
    assign proc      = in_vld_reg & buf_free;
    assign in_stall  = in_vld_reg & ~buf_free;

    // result mux
    assign kind         = byte_vld_reg ? KIND_BYTE : stat_kind_reg;
    assign decoded_byte = byte_vld_reg ? byte_reg : '0;
    assign hex_high     = byte_vld_reg ? hh_reg : HEX_ZERO;
    assign hex_low      = byte_vld_reg ? hl_reg : HEX_ZERO;
    assign byte_index   = byte_vld_reg ? idx_reg : '0;
    assign run_end      = ~byte_vld_reg | ~stat_vld_reg;

    // per-character decode
    always_comb
    begin
        hv         = hex_value(in_char_reg);
        not_full   = cnt_reg < CNT_FULL;
        emit       = 1'b0;
        emit_byte  = in_char_reg;
        phase_next = phase_reg;
        nib_next   = nib_reg;
        bad_next   = bad_reg;
        stat_kind  = KIND_OK;
        unique case (phase_reg)
            PH_FIRST:
            begin
                if (!hv[4])
                begin
                    bad_next = 1'b1;
                end
                nib_next   = hv[3:0];
                phase_next = PH_SECOND;
            end
            PH_SECOND:
            begin
                phase_next = PH_IDLE;
                if (!hv[4])
                begin
                    bad_next = 1'b1;
                end
                // a bad first digit suppresses the byte
                if (hv[4] && !bad_reg && not_full)
                begin
                    emit      = 1'b1;
                    emit_byte = {nib_reg, hv[3:0]};
                end
                nib_next = 4'd0;
            end
            PH_IDLE:
            begin
                if (not_full)
                begin
                    if (in_char_reg == PERCENT_CHAR)
                    begin
                        phase_next = PH_FIRST;
                    end
                    else
                    begin
                        emit = 1'b1;
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
        cnt_stepped = cnt_reg + CNT_W'(emit);
        cnt_next    = cnt_stepped;

        // closing status, then back to the reset state
        priority if (phase_next != PH_IDLE || bad_next)
        begin
            stat_kind = KIND_BADESC;
        end
        else if (cnt_stepped < CNT_FULL)
        begin
            stat_kind = KIND_SHORT;
        end
        else
        begin
            stat_kind = KIND_OK;
        end
        if (in_last_reg)
        begin
            phase_next = PH_IDLE;
            nib_next   = 4'd0;
            cnt_next   = '0;
            bad_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_char_reg <= char_in;
            in_last_reg <= last_char;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            nib_reg   <= 4'd0;
            cnt_reg   <= '0;
            bad_reg   <= 1'b0;
        end
        else if (proc)
        begin
            phase_reg <= phase_next;
            nib_reg   <= nib_next;
            cnt_reg   <= cnt_next;
            bad_reg   <= bad_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_vld_reg <= 1'b0;
            stat_vld_reg <= 1'b0;
        end
        else if (proc)
        begin
            byte_vld_reg <= emit;
            stat_vld_reg <= in_last_reg;
        end
        else if (out_take)
        begin
            if (byte_vld_reg)
            begin
                byte_vld_reg <= 1'b0;
            end
            else
            begin
                stat_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            byte_reg      <= emit_byte;
            hh_reg        <= hex_digit(emit_byte[7:4]);
            hl_reg        <= hex_digit(emit_byte[3:0]);
            idx_reg       <= IDX_W'(cnt_reg);
            stat_kind_reg <= stat_kind;
        end
    end

    // byte count never passes the hash length
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_FULL)
        else $error("byte count beyond hash length");

    // a closing character leaves the decoder in its reset state
    a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
        proc && in_last_reg |=> phase_reg == PH_IDLE && cnt_reg == '0 && !bad_reg)
        else $error("state not cleared after closing character");

    // byte results carry matching hex digits and an index inside the hash
    a_byte_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_BYTE |->
            hex_high == hex_digit(decoded_byte[7:4]) &&
            hex_low == hex_digit(decoded_byte[3:0]) &&
            {1'b0, byte_index} < (IDX_W + 1)'(HASH_BYTES))
        else $error("inconsistent byte result");

    // a status result is always the final result of its character
    a_stat_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_BYTE |-> run_end)
        else $error("status result without run_end");

endmodule

// File: bench/testbench.sv
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import pdh_pkg::*;

    // hash length the decoder is built with (default parameter)
    localparam int HASH_LEN = HASH_BYTES_DEF;

    // ascii bounds of the hex digit ranges
    localparam logic [7:0] CH_DIGIT_LO = 8'h30;
    localparam logic [7:0] CH_DIGIT_HI = 8'h39;
    localparam logic [7:0] CH_LOWER_A  = 8'h61;
    localparam logic [7:0] CH_LOWER_F  = 8'h66;
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [7:0] CH_UPPER_F  = 8'h46;

    // one result as it should leave the decoder
    typedef struct {
        kind_t      kind;
        logic [7:0] dbyte;
        logic [6:0] hi;
        logic [6:0] lo;
        logic [4:0] idx;
        logic       fin;
    } hash_result_t;

    // clock and reset
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // request side, all inputs known from time zero
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] char_in = 8'h00;
    logic       last_char = 1'b0;

    // result side
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [1:0] kind;
    logic [7:0] decoded_byte;
    logic [6:0] hex_high;
    logic [6:0] hex_low;
    logic [4:0] byte_index;
    logic       run_end;

    // decoder state as predicted on the bench side
    phase_t     esc_phase = PH_IDLE;
    logic [3:0] esc_nibble = 4'd0;
    int         byte_count = 0;
    bit         esc_bad = 1'b0;

    // results still owed by the decoder, oldest first
    hash_result_t hash_results_due[$];
    hash_result_t head;

    // failure bookkeeping
    int mismatches = 0;
    int fail_count = 0;

    // requests that reach the decoding logic (ignored ones are not counted)
    int chars_counted = 0;

    // idling controls shared by the sender and the receiver
    bit tx_idle_en = 1'b0;
    bit rx_idle_en = 1'b0;
    int rx_hold_request = 0;
    int rx_left = 0;

    always #5 clk = ~clk;

    percent_decode_hash_to_hex_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .char_in      (char_in),
        .last_char    (last_char),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .decoded_byte (decoded_byte),
        .hex_high     (hex_high),
        .hex_low      (hex_low),
        .byte_index   (byte_index),
        .run_end      (run_end)
    );

    // value of an ascii hex digit in either case, zero when not a digit
    function automatic bit ascii_hex(input logic [7:0] ch, output logic [3:0] val);
        logic [7:0] d;
        d = 8'd0;
        val = 4'd0;
        if (ch >= CH_DIGIT_LO && ch <= CH_DIGIT_HI)
        begin
            d = ch - CH_DIGIT_LO;
        end
        else if (ch >= CH_LOWER_A && ch <= CH_LOWER_F)
        begin
            d = ch - CH_LOWER_A + 8'd10;
        end
        else if (ch >= CH_UPPER_A && ch <= CH_UPPER_F)
        begin
            d = ch - CH_UPPER_A + 8'd10;
        end
        else
        begin
            return 1'b0;
        end
        val = d[3:0];
        return 1'b1;
    endfunction

    // lowercase ascii for one nibble
    function automatic logic [6:0] nibble_ascii(input logic [3:0] n);
        if (n < 4'd10)
        begin
            return HEX_ZERO + {3'b000, n};
        end
        return CH_LOWER_A[6:0] + {3'b000, n - 4'd10};
    endfunction

    // work out the results of one accepted character and queue them
    function automatic void decode_char(input logic [7:0] c, input logic last);
        hash_result_t r;
        logic [3:0]   v;
        logic [7:0]   b;
        bit           v_ok;
        bit           emit;
        v_ok = ascii_hex(c, v);
        emit = 1'b0;
        b = 8'h00;
        case (esc_phase)
            PH_FIRST:
            begin
                if (!v_ok)
                begin
                    esc_bad = 1'b1;
                end
                esc_nibble = v;
                esc_phase = PH_SECOND;
            end
            PH_SECOND:
            begin
                // the sticky flag is looked at before this digit can set it
                if (v_ok && !esc_bad && byte_count < HASH_LEN)
                begin
                    emit = 1'b1;
                    b = {esc_nibble, v};
                end
                if (!v_ok)
                begin
                    esc_bad = 1'b1;
                end
                esc_phase = PH_IDLE;
                esc_nibble = 4'd0;
            end
            default:
            begin
                // a full hash ignores everything, percent included
                if (byte_count < HASH_LEN)
                begin
                    if (c == PERCENT_CHAR)
                    begin
                        esc_phase = PH_FIRST;
                    end
                    else
                    begin
                        emit = 1'b1;
                        b = c;
                    end
                end
            end
        endcase
        if (emit)
        begin
            r.kind = KIND_BYTE;
            r.dbyte = b;
            r.hi = nibble_ascii(b[7:4]);
            r.lo = nibble_ascii(b[3:0]);
            r.idx = 5'(byte_count);
            r.fin = !last;
            hash_results_due.push_back(r);
            byte_count++;
        end
        if (last)
        begin
            // unfinished or bad escape wins over a short hash
            if (esc_phase != PH_IDLE || esc_bad)
            begin
                r.kind = KIND_BADESC;
            end
            else if (byte_count < HASH_LEN)
            begin
                r.kind = KIND_SHORT;
            end
            else
            begin
                r.kind = KIND_OK;
            end
            r.dbyte = 8'h00;
            r.hi = HEX_ZERO;
            r.lo = HEX_ZERO;
            r.idx = 5'd0;
            r.fin = 1'b1;
            hash_results_due.push_back(r);
            esc_phase = PH_IDLE;
            esc_nibble = 4'd0;
            byte_count = 0;
            esc_bad = 1'b0;
        end
    endfunction

    // offer one character, wait for the request to go through, then maybe idle
    task automatic send_char(input logic [7:0] c, input logic last);
        in_valid <= 1'b1;
        char_in <= c;
        last_char <= last;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        // request taken at this edge
        if (!(esc_phase == PH_IDLE && byte_count >= HASH_LEN && !last))
        begin
            chars_counted++;
        end
        decode_char(c, last);
        if (tx_idle_en && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    // sender pauses until every owed result has come out
    task automatic wait_drained();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (hash_results_due.size() != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        // then let anything still in flight settle
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [7:0] rand_literal();
        logic [7:0] c;
        do
        begin
            c = 8'($urandom_range(0, 255));
        end
        while (c == PERCENT_CHAR);
        return c;
    endfunction

    function automatic logic [7:0] rand_non_hex();
        logic [7:0] c;
        logic [3:0] v;
        do
        begin
            c = 8'($urandom_range(0, 255));
        end
        while (ascii_hex(c, v));
        return c;
    endfunction

    function automatic logic [7:0] rand_hex_char();
        logic [3:0] v;
        v = 4'($urandom_range(0, 15));
        if (v < 4'd10)
        begin
            return CH_DIGIT_LO + {4'd0, v};
        end
        if ($urandom_range(0, 1) == 0)
        begin
            return CH_UPPER_A + {4'd0, v - 4'd10};
        end
        return CH_LOWER_A + {4'd0, v - 4'd10};
    endfunction

    // one whole encoded value: mostly well formed, some broken, some noise
    task automatic send_random_value();
        logic [7:0] chars[$];
        int         n_bytes;
        int         flavour;
        int         bad_at;
        flavour = $urandom_range(0, 9);
        // most values reach a full hash, some stop short
        n_bytes = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : $urandom_range(20, 24);
        bad_at = $urandom_range(0, n_bytes - 1);
        if (flavour == 0)
        begin
            // pure noise
            repeat ($urandom_range(1, 30)) chars.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            for (int i = 0; i < n_bytes; i++)
            begin
                if (flavour == 1 && i == bad_at)
                begin
                    // escape with a non-hex digit in either place
                    chars.push_back(PERCENT_CHAR);
                    if ($urandom_range(0, 1) == 0)
                    begin
                        chars.push_back(rand_non_hex());
                        chars.push_back(8'($urandom_range(0, 255)));
                    end
                    else
                    begin
                        chars.push_back(rand_hex_char());
                        chars.push_back(rand_non_hex());
                    end
                end
                else if ($urandom_range(0, 2) == 0)
                begin
                    chars.push_back(PERCENT_CHAR);
                    chars.push_back(rand_hex_char());
                    chars.push_back(rand_hex_char());
                end
                else
                begin
                    chars.push_back(rand_literal());
                end
            end
            if (flavour == 2)
            begin
                // value stops inside an escape
                chars.push_back(PERCENT_CHAR);
                if ($urandom_range(0, 1) == 0)
                begin
                    chars.push_back(rand_hex_char());
                end
            end
        end
        foreach (chars[i])
        begin
            send_char(chars[i], i == chars.size() - 1);
        end
    endtask

    // escapes, both cases, boundary non-hex digits, endings inside an escape
    task automatic test_escapes();
        send_char(8'h00, 1'b1);
        send_char(PERCENT_CHAR, 1'b0);
        send_char("F", 1'b0);
        send_char("F", 1'b1);
        send_char(PERCENT_CHAR, 1'b0);
        send_char("0", 1'b0);
        send_char("a", 1'b0);
        send_char(8'hFF, 1'b1);
        send_char(PERCENT_CHAR, 1'b0);
        send_char("7", 1'b1);
        send_char(PERCENT_CHAR, 1'b1);
        // bad first digit stays sticky past later literals
        send_char(PERCENT_CHAR, 1'b0);
        send_char("g", 1'b0);
        send_char("1", 1'b0);
        send_char("A", 1'b1);
        send_char(PERCENT_CHAR, 1'b0);
        send_char("1", 1'b0);
        send_char("/", 1'b1);
        send_char(PERCENT_CHAR, 1'b0);
        send_char("@", 1'b0);
        send_char("G", 1'b1);
    endtask

    // full hash closing on its last byte, then one with an ignored tail
    task automatic test_full_hash();
        for (int i = 0; i < HASH_LEN; i++)
        begin
            send_char((i == 0) ? 8'h00 : (i == 1) ? 8'hFF : rand_literal(), i == HASH_LEN - 1);
        end
        send_char(PERCENT_CHAR, 1'b0);
        send_char("4", 1'b0);
        send_char("1", 1'b0);
        for (int i = 1; i < HASH_LEN; i++)
        begin
            send_char(rand_literal(), 1'b0);
        end
        // hash is full now: percent and digits fall through unused
        send_char(PERCENT_CHAR, 1'b0);
        send_char("5", 1'b1);
    endtask

    // receiver holds off long enough for the decoder to stall its input
    task automatic test_backpressure();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        rx_hold_request = 60;
        for (int i = 0; i < 30; i++)
        begin
            send_char(rand_literal(), i == 29);
        end
        wait_drained();
    endtask

    // random values with idling in bursts, some stretches without
    task automatic test_random_values();
        while (chars_counted < 900)
        begin
            tx_idle_en = ($urandom_range(0, 3) != 0);
            rx_idle_en = ($urandom_range(0, 3) != 0);
            send_random_value();
        end
    endtask

    // closing stretch at full rate on both sides
    task automatic test_random_no_idle();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        while (chars_counted < 1000)
        begin
            send_random_value();
        end
    endtask

    // receiver: long hold when asked, otherwise random stall bursts
    always @(posedge clk)
    begin
        if (rx_hold_request > 0)
        begin
            rx_left = rx_hold_request;
            rx_hold_request = 0;
        end
        if (rx_left > 0)
        begin
            out_stall <= 1'b1;
            rx_left--;
        end
        else if (rx_idle_en && $urandom_range(0, 5) == 0)
        begin
            out_stall <= 1'b1;
            rx_left = int'($urandom_range(1, 8)) - 1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // result checker: every result taken is matched against the oldest owed one
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (hash_results_due.size() == 0)
            begin
                if (mismatches < 10)
                begin
                    $display("unexpected result at %0t: kind %0d byte %02h idx %0d", $realtime,
                             kind, decoded_byte, byte_index);
                end
                mismatches++;
                fail_count++;
            end
            else
            begin
                head = hash_results_due.pop_front();
                if (kind !== head.kind || decoded_byte !== head.dbyte || hex_high !== head.hi
                    || hex_low !== head.lo || byte_index !== head.idx || run_end !== head.fin)
                begin
                    if (mismatches < 10)
                    begin
                        $display("mismatch at %0t (expected/actual): kind %0d/%0d byte %02h/%02h",
                                 $realtime, head.kind, kind, head.dbyte, decoded_byte);
                        $display("  hex %0d,%0d/%0d,%0d idx %0d/%0d end %0d/%0d", head.hi,
                                 head.lo, hex_high, hex_low, head.idx, byte_index, head.fin,
                                 run_end);
                    end
                    mismatches++;
                    fail_count++;
                end
            end
        end
    end

    // overall time limit
    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        // reset held from time zero, released on a clock edge
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_escapes();
        wait_drained();
        test_full_hash();
        wait_drained();
        test_backpressure();
        test_random_values();
        test_random_no_idle();
        wait_drained();

        if (hash_results_due.size() != 0)
        begin
            $display("%0d expected results never arrived", hash_results_due.size());
            fail_count += hash_results_due.size();
        end
        if (fail_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
